// ----- rtl/core/fir_pkg.sv -----
// Shared types and constants for the Q1.15 FIR filter.
package fir_pkg;

    localparam int TAPS_DEF = 32;
    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 32;
    localparam int SHIFT_W  = 5;
    localparam int IDX_W    = 5;

    // Wide enough to hold any tap index and the largest tap count
    localparam int CMP_W = 9;

    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_LOAD   = 1'b1;

    localparam logic [SHIFT_W-1:0] FRAC_SHIFT_RST = 5'd15;

    // Per-tap control sent from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic issue;   // reads for one tap issued this cycle
        logic first;   // tap 0: restart the sum
        logic last;    // final tap of the sample
        logic live;    // both delay entry and coefficient hold written data
    } mac_ctl_t;

endpackage

// ----- rtl/core/fir_if.sv -----
// Request channels of the FIR filter: sample/coefficient in, filtered sample out.
interface fir_in_if import fir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic        [IDX_W-1:0]    tap_index;
    logic signed [SAMPLE_W-1:0] sample_value;

    modport source (output valid, output func, output tap_index, output sample_value,
                    input ready);
    modport sink   (input valid, input func, input tap_index, input sample_value,
                    output ready);
endinterface

interface fir_out_if import fir_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);
endinterface

// ----- rtl/core/fir_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module fir_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/fir_ctrl.sv -----
// Sequencer: request intake, delay-line pointers, tap loop and result register.
module fir_ctrl import fir_pkg::*; #(
    parameter int TAPS = TAPS_DEF,
    parameter int AW   = (TAPS > 1) ? $clog2(TAPS) : 1,
    parameter int CW   = $clog2(TAPS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    fir_in_if.sink                     samples,
    fir_out_if.source                  results,
    output logic                       dl_we,
    output logic        [AW-1:0]       dl_waddr,
    output logic signed [SAMPLE_W-1:0] dl_wdata,
    output logic        [AW-1:0]       dl_raddr,
    output logic                       cf_we,
    output logic        [AW-1:0]       cf_waddr,
    output logic signed [SAMPLE_W-1:0] cf_wdata,
    output logic        [AW-1:0]       cf_raddr,
    output mac_ctl_t                   ctl,
    input  logic                       sum_done,
    input  logic signed [SAMPLE_W-1:0] sum_q15
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [AW-1:0] LAST_TAP = AW'(TAPS - 1);
    localparam logic [CW-1:0] FULL     = CW'(TAPS);

    logic [1:0]                 state_reg, state_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              rd_reg, rd_next;
    logic [AW-1:0]              tap_reg, tap_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [TAPS-1:0]            cvalid_reg, cvalid_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_data_reg, out_data_next;

    logic             accept;
    logic             start;
    logic [CMP_W-1:0] idx_wide;
    logic             is_last;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign start         = accept && (samples.func == FUNC_FILTER);
    assign idx_wide      = {{(CMP_W-IDX_W){1'b0}}, samples.tap_index};

    // Coefficient write; drop indexes beyond the table
    assign cf_we    = accept && (samples.func == FUNC_LOAD) && (idx_wide < CMP_W'(TAPS));
    assign cf_waddr = idx_wide[AW-1:0];
    assign cf_wdata = samples.sample_value;

    // New sample goes to the head of the circular delay line
    assign dl_we    = start;
    assign dl_waddr = head_reg;
    assign dl_wdata = samples.sample_value;

    assign dl_raddr = rd_reg;
    assign cf_raddr = tap_reg;
    assign is_last  = (tap_reg == LAST_TAP);

    always_comb
    begin
        ctl.issue = (state_reg == ST_RUN);
        ctl.first = (tap_reg == '0);
        ctl.last  = is_last;
        ctl.live  = cvalid_reg[tap_reg] && (CW'(tap_reg) < fill_reg);
    end

    assign results.valid           = out_valid_reg;
    assign results.filtered_sample = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        rd_next        = rd_reg;
        tap_next       = tap_reg;
        fill_next      = fill_reg;
        cvalid_next    = cvalid_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;

        if (cf_we)
        begin
            cvalid_next[cf_waddr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rd_next   = head_reg;
                    tap_next  = '0;
                    head_next = (head_reg == LAST_TAP) ? '0 : head_reg + 1'b1;
                    if (fill_reg != FULL)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // Walk back through the delay line, oldest sample last
                rd_next  = (rd_reg == '0) ? LAST_TAP : rd_reg - 1'b1;
                tap_next = tap_reg + 1'b1;
                if (is_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sum_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = sum_q15;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            rd_reg        <= '0;
            tap_reg       <= '0;
            fill_reg      <= '0;
            cvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            rd_reg        <= rd_next;
            tap_reg       <= tap_next;
            fill_reg      <= fill_next;
            cvalid_reg    <= cvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// ----- rtl/core/fir_mac.sv -----
// Multiply-accumulate unit with the fraction-shift register and output scaling.
module fir_mac import fir_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic        [SHIFT_W-1:0]  cfg_wr_data,
    input  mac_ctl_t                   ctl,
    input  logic signed [SAMPLE_W-1:0] dl_rdata,
    input  logic signed [SAMPLE_W-1:0] cf_rdata,
    output logic                       sum_done,
    output logic signed [SAMPLE_W-1:0] sum_q15
);

    mac_ctl_t                ctl_d1_reg;
    logic                    pv_reg, pfirst_reg, plast_reg;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                    done_reg;
    logic [SHIFT_W-1:0]      shift_reg;
    logic signed [ACC_W-1:0] shifted;

    // Zero the term when either operand was never written since reset
    always_comb
    begin
        if (ctl_d1_reg.live)
        begin
            prod_next = dl_rdata * cf_rdata;
        end
        else
        begin
            prod_next = '0;
        end
    end

    // Sum wraps modulo 2^32
    always_comb
    begin
        acc_next = acc_reg;
        if (pv_reg)
        begin
            acc_next = pfirst_reg ? prod_reg : acc_reg + prod_reg;
        end
    end

    assign shifted  = acc_reg >>> shift_reg;
    assign sum_q15  = shifted[SAMPLE_W-1:0];
    assign sum_done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d1_reg <= '0;
            pv_reg     <= 1'b0;
            pfirst_reg <= 1'b0;
            plast_reg  <= 1'b0;
            done_reg   <= 1'b0;
            shift_reg  <= FRAC_SHIFT_RST;
        end
        else
        begin
            ctl_d1_reg <= ctl;
            pv_reg     <= ctl_d1_reg.issue;
            pfirst_reg <= ctl_d1_reg.first;
            plast_reg  <= ctl_d1_reg.last;
            done_reg   <= pv_reg && plast_reg;
            if (cfg_wr_en)
            begin
                shift_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

endmodule

// ----- rtl/core/fir_filter_q15.sv -----
// A sample request is accepted only while the sequencer is idle, and the next request waits
// until the result of the last is registered; the single shared multiply-accumulate
// reads one delay entry and one coefficient from the two RAMs per cycle.
// Coefficient loads produce no result.
// Reset: rst_n, asynchronous active low; clears delay-line fill count, coefficient
// valid bits and sets frac_shift to 15, so every tap reads as zero until written.
module fir_filter_q15 import fir_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    fir_in_if.sink             samples,
    fir_out_if.source          results,
    input  logic               cfg_wr_en,
    input  logic [SHIFT_W-1:0] cfg_wr_data
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CW = $clog2(TAPS + 1);

    // Delay-line RAM port signals (circular buffer, head advances per sample)
    logic                       dl_we;
    logic        [AW-1:0]       dl_waddr;
    logic signed [SAMPLE_W-1:0] dl_wdata;
    logic        [AW-1:0]       dl_raddr;
    logic signed [SAMPLE_W-1:0] dl_rdata;

    // Coefficient RAM port signals
    logic                       cf_we;
    logic        [AW-1:0]       cf_waddr;
    logic signed [SAMPLE_W-1:0] cf_wdata;
    logic        [AW-1:0]       cf_raddr;
    logic signed [SAMPLE_W-1:0] cf_rdata;

    mac_ctl_t                   ctl;
    logic                       sum_done;
    logic signed [SAMPLE_W-1:0] sum_q15;

    // Sequence requests: write the sample, step one tap per cycle, hold the result
    fir_ctrl #(
        .TAPS (TAPS),
        .AW   (AW),
        .CW   (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .results  (results),
        .dl_we    (dl_we),
        .dl_waddr (dl_waddr),
        .dl_wdata (dl_wdata),
        .dl_raddr (dl_raddr),
        .cf_we    (cf_we),
        .cf_waddr (cf_waddr),
        .cf_wdata (cf_wdata),
        .cf_raddr (cf_raddr),
        .ctl      (ctl),
        .sum_done (sum_done),
        .sum_q15  (sum_q15)
    );

    // Hold the delay line; the newest sample lands at the head pointer
    fir_ram #(
        .WIDTH  (SAMPLE_W),
        .DEPTH  (TAPS),
        .ADDR_W (AW)
    ) u_delay_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (dl_raddr),
        .rdata (dl_rdata)
    );

    // Hold the coefficient table, indexed by tap number
    fir_ram #(
        .WIDTH  (SAMPLE_W),
        .DEPTH  (TAPS),
        .ADDR_W (AW)
    ) u_coef_ram (
        .clk   (clk),
        .we    (cf_we),
        .waddr (cf_waddr),
        .wdata (cf_wdata),
        .raddr (cf_raddr),
        .rdata (cf_rdata)
    );

    // Multiply, accumulate with 32-bit wrap, then shift right by frac_shift
    fir_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .dl_rdata    (dl_rdata),
        .cf_rdata    (cf_rdata),
        .sum_done    (sum_done),
        .sum_q15     (sum_q15)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the Q1.15 FIR filter: directed table, then random phases.
module testbench;
    import fir_pkg::*;

    // Filter length under test; the mirror below tracks the same number of taps.
    localparam int N_TAPS = TAPS_DEF;
    // Cycles to let a coefficient load or a late result settle before touching config.
    localparam int SETTLE_CYCLES = N_TAPS + 10;
    // Long receiver hold-off used to back the pipeline up into the input channel.
    localparam int HOLD_CYCLES = 600;
    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 172;
    localparam int DIR_COUNT = 22;

    // Flow-control patterns applied per phase.
    typedef enum int {PACE_FREE, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;

    // One row of the directed table; want is used only where known is set.
    typedef struct {
        logic                       func;
        logic        [IDX_W-1:0]    tap;
        logic signed [SAMPLE_W-1:0] value;
        bit                         known;
        logic signed [SAMPLE_W-1:0] want;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic               cfg_wr_en;
    logic [SHIFT_W-1:0] cfg_wr_data;

    fir_in_if  samples_if();
    fir_out_if results_if();

    fir_filter_q15 #(.TAPS(N_TAPS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_if.sink),
        .results     (results_if.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Mirror of the filter state: delay line, coefficient table, fraction shift.
    logic signed [SAMPLE_W-1:0] delay_taps [N_TAPS];
    logic signed [SAMPLE_W-1:0] coef_mirror [N_TAPS];
    logic        [SHIFT_W-1:0]  shift_mirror;

    // Filtered samples still owed by the block, oldest first.
    logic signed [SAMPLE_W-1:0] owed_outputs [$];

    int    errors = 0;
    pace_t pace = PACE_FREE;
    bit    hold_wanted = 1'b0;
    int    hold_left = 0;
    int    quiet_cycles = 0;

    // Directed stimulus. Rows with known set carry a result that follows at a glance:
    // right after reset every coefficient is zero, so the first two samples give zero.
    // The rest load extremes into taps 0, 1 and 31, force the accumulator past 2^31,
    // put a nonzero index on sample requests, and toggle every index and value bit.
    dir_row_t dir_plan [DIR_COUNT] = '{
        '{FUNC_FILTER, 5'd0,  16'h7FFF, 1'b1, 16'h0000},
        '{FUNC_FILTER, 5'd31, 16'h8000, 1'b1, 16'h0000},
        '{FUNC_LOAD,   5'd0,  16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_LOAD,   5'd31, 16'h8000, 1'b0, 16'h0000},
        '{FUNC_LOAD,   5'd1,  16'h8000, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h8000, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd17, 16'h8000, 1'b0, 16'h0000},
        '{FUNC_LOAD,   5'd0,  16'h8000, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h8000, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h0000, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h0001, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'hFFFF, 1'b0, 16'h0000},
        '{FUNC_LOAD,   5'd2,  16'h0001, 1'b0, 16'h0000},
        '{FUNC_LOAD,   5'd3,  16'hFFFF, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd21, 16'h5555, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd10, 16'hAAAA, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_LOAD,   5'd15, 16'h1234, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h8000, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h0000, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h7FFF, 1'b0, 16'h0000},
        '{FUNC_FILTER, 5'd0,  16'h8000, 1'b0, 16'h0000}
    };

    // Frac shift and flow-control pattern for each random phase; extremes included.
    logic [SHIFT_W-1:0] phase_shift [PHASE_COUNT];
    pace_t phase_pace [PHASE_COUNT] = '{
        PACE_FREE, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH,
        PACE_FREE, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Shift the new sample into the mirrored delay line and form the wrapped
    // 32-bit dot product, then shift it arithmetically and keep the low half.
    function automatic logic signed [SAMPLE_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] x);
        logic signed [ACC_W-1:0] acc;
        int k;
        for (k = N_TAPS - 1; k > 0; k--)
            delay_taps[k] = delay_taps[k-1];
        delay_taps[0] = x;
        acc = '0;
        for (k = 0; k < N_TAPS; k++)
            acc += delay_taps[k] * coef_mirror[k];
        acc = acc >>> shift_mirror;
        return acc[SAMPLE_W-1:0];
    endfunction

    function automatic bit source_gaps();
        case (pace)
            PACE_SRC_GAPS: return $urandom_range(99) < 88;
            PACE_BOTH:     return $urandom_range(99) < 8;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit sink_stalls();
        case (pace)
            PACE_SINK_STALLS: return $urandom_range(99) < 88;
            PACE_BOTH:        return $urandom_range(99) < 8;
            default:          return 1'b0;
        endcase
    endfunction

    // Mostly uniform values, with a share of the corner patterns mixed in.
    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        if ($urandom_range(99) < 12)
        begin
            case ($urandom_range(4))
                0:       return 16'h7FFF;
                1:       return 16'h8000;
                2:       return 16'h0000;
                3:       return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        return SAMPLE_W'($urandom);
    endfunction

    // Offer one request and hold it until the block takes it. Valid stays high on
    // return so back-to-back requests never lower and raise it in the same step.
    task automatic push_request(input logic f, input logic [IDX_W-1:0] t,
                                input logic signed [SAMPLE_W-1:0] v,
                                input bit known, input logic signed [SAMPLE_W-1:0] want);
        logic signed [SAMPLE_W-1:0] predicted;
        while (source_gaps())
        begin
            samples_if.valid <= 1'b0;
            @(posedge clk);
        end
        samples_if.valid        <= 1'b1;
        samples_if.func         <= f;
        samples_if.tap_index    <= t;
        samples_if.sample_value <= v;
        @(posedge clk);
        while (!samples_if.ready)
            @(posedge clk);
        // Accepted at this edge: advance the mirror.
        if (f == FUNC_LOAD)
        begin
            if (t < N_TAPS)
                coef_mirror[t] = v;
        end
        else
        begin
            predicted = filter_sample(v);
            owed_outputs.push_back(known ? want : predicted);
        end
    endtask

    // Drop valid, wait for every owed output, then let a trailing load finish.
    task automatic settle();
        samples_if.valid <= 1'b0;
        while (owed_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_frac_shift(input logic [SHIFT_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        shift_mirror = v;
    endtask

    // Result side: either a long hold-off when asked, or ready per the current pace.
    initial
    begin
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                hold_left = HOLD_CYCLES;
                results_if.ready <= 1'b0;
            end
            else
                results_if.ready <= !sink_stalls();
        end
    end

    // Compare each accepted result with the oldest owed output.
    always @(posedge clk)
    begin
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (owed_outputs.size() == 0)
            begin
                $display("%0t: unexpected filtered_sample %0d, expected none",
                         $time, results_if.filtered_sample);
                errors++;
            end
            else
            begin
                want = owed_outputs.pop_front();
                if (results_if.filtered_sample !== want)
                begin
                    $display("%0t: filtered_sample mismatch, expected %0d, actual %0d",
                             $time, want, results_if.filtered_sample);
                    errors++;
                end
            end
        end
    end

    // Hang detector: count cycles in which neither channel completes a request.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((samples_if.valid && samples_if.ready) ||
                (results_if.valid && results_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        int n;
        logic f;

        // Hold every input at a known value from time zero.
        rst_n                   <= 1'b0;
        samples_if.valid        <= 1'b0;
        samples_if.func         <= FUNC_FILTER;
        samples_if.tap_index    <= '0;
        samples_if.sample_value <= '0;
        cfg_wr_en               <= 1'b0;
        cfg_wr_data             <= FRAC_SHIFT_RST;

        for (n = 0; n < N_TAPS; n++)
        begin
            delay_taps[n]  = '0;
            coef_mirror[n] = '0;
        end
        shift_mirror = FRAC_SHIFT_RST;

        phase_shift[0] = 5'd15;
        phase_shift[1] = 5'd0;
        phase_shift[2] = 5'd31;
        phase_shift[3] = SHIFT_W'($urandom_range(31));
        phase_shift[4] = 5'd1;
        phase_shift[5] = 5'd30;
        phase_shift[6] = SHIFT_W'($urandom_range(31));
        phase_shift[7] = 5'd15;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset shift, no idling.
        pace = PACE_FREE;
        foreach (dir_plan[i])
            push_request(dir_plan[i].func, dir_plan[i].tap, dir_plan[i].value,
                         dir_plan[i].known, dir_plan[i].want);
        settle();

        // Random phases: a new shift and pace each time, drained in between.
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            write_frac_shift(phase_shift[p]);
            pace = phase_pace[p];
            // First phase: back the block up behind a long receiver hold-off.
            if (p == 0)
                hold_wanted = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                f = ($urandom_range(99) < 20) ? FUNC_LOAD : FUNC_FILTER;
                push_request(f, IDX_W'($urandom_range(N_TAPS - 1)), pick_value(),
                             1'b0, '0);
            end
            settle();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
